>>> rtl/core/pasm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pasm_pkg
// Shared types and codes of the polynomial add / subtract / multiply engine.
// ----------------------------------------------------------------------------
package pasm_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned RESULT_W = 40;
  localparam int unsigned POWER_W  = 6;
  localparam int unsigned TERM_W   = 2 * COEF_W;

  // Item kinds carried in tuser of the input stream
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUB    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MUL    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

  // Operation run by the datapath
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_e;

  // One coefficient-pair read issued to the datapath
  typedef struct packed {
    logic vld;
    logic a_ok;
    logic b_ok;
  } issue_t;

endpackage : pasm_pkg
`default_nettype wire

>>> rtl/core/polynomial_add_sub_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul
// Two coefficient stores in RAM with add, subtract and convolution engine.
// ----------------------------------------------------------------------------
// Load words (kind 0 / 1) push a coefficient into operand A or B, highest
// power first; loads into a full operand are dropped.
// Kind 5 clears both operands. Add, subtract and multiply emit their result
// coefficients lowest power first on the output stream, tlast on the final
// one; an empty result gives a single zero. Coefficient k is built by
// reading both RAMs once per contributing pair through a three-stage
// multiply-accumulate path, which is drained before the coefficient is
// handed off. One word is worked on at a time: the input is not ready
// until the last result is taken, and is ready again in the cycle after.
module polynomial_add_sub_mul #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] coefficient
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [39:0] result_value, [45:40] power, zero pad
  output logic             m_axis_tlast
);
  import pasm_pkg::*;

  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned LW = $clog2(MAX_TERMS + 1);
  localparam int unsigned IW = LW + 1;
  localparam logic [LW-1:0] FULL = LW'(MAX_TERMS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [LW-1:0]     la_q, la_d;
  logic [LW-1:0]     lb_q, lb_d;
  op_e               op_q, op_d;
  logic              zero_q, zero_d;
  logic [IW-1:0]     n_q, n_d;
  logic [IW-1:0]     k_q, k_d;
  logic [IW-1:0]     i_q, i_d;
  logic              start_k;
  logic              s_fire;
  logic              m_fire;
  logic              last_k;
  logic              last_issue;
  logic [IW-1:0]     k_nxt;
  logic [IW-1:0]     ilo;
  logic [IW-1:0]     ihi;
  logic [IW-1:0]     la_w, lb_w;
  logic [LW-1:0]     lmax;
  logic [IW-1:0]     ia, jb;
  logic [IW-1:0]     a_addr_w, b_addr_w;
  logic              we_a, we_b;
  logic [COEF_W-1:0] rd_a, rd_b;
  issue_t            issue;
  logic [RESULT_W-1:0] acc;
  logic              mac_busy;

  assign s_fire = s_axis_tvalid & s_axis_tready;
  assign m_fire = m_axis_tvalid & m_axis_tready;
  assign la_w   = {1'b0, la_q};
  assign lb_w   = {1'b0, lb_q};
  assign lmax   = (la_q > lb_q) ? la_q : lb_q;
  assign last_k = (k_q == n_q - IW'(1));

  // First and last A index that meets B for the coefficient being started / run
  assign k_nxt = (state_q == ST_OUT) ? k_q + IW'(1) : '0;
  assign ilo   = (k_nxt >= lb_w) ? k_nxt - lb_w + IW'(1) : '0;
  assign ihi   = (k_q < la_w) ? k_q : la_w - IW'(1);
  assign last_issue = (op_q != OP_MUL) || zero_q || (i_q == ihi);

  // Sequencer
  always_comb begin
    state_d = state_q;
    la_d    = la_q;
    lb_d    = lb_q;
    op_d    = op_q;
    zero_d  = zero_q;
    n_d     = n_q;
    k_d     = k_q;
    i_d     = i_q;
    start_k = 1'b0;
    we_a    = 1'b0;
    we_b    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (s_axis_tuser) inside
            KIND_LOAD_A: begin
              if (la_q < FULL) begin
                we_a = 1'b1;
                la_d = la_q + LW'(1);
              end
            end
            KIND_LOAD_B: begin
              if (lb_q < FULL) begin
                we_b = 1'b1;
                lb_d = lb_q + LW'(1);
              end
            end
            KIND_CLEAR: begin
              la_d = '0;
              lb_d = '0;
            end
            KIND_ADD, KIND_SUB: begin
              op_d    = (s_axis_tuser == KIND_ADD) ? OP_ADD : OP_SUB;
              zero_d  = (lmax == '0);
              n_d     = (lmax == '0) ? IW'(1) : {1'b0, lmax};
              k_d     = '0;
              i_d     = '0;
              start_k = 1'b1;
              state_d = ST_RUN;
            end
            KIND_MUL: begin
              op_d    = OP_MUL;
              zero_d  = (la_q == '0) || (lb_q == '0);
              n_d     = ((la_q == '0) || (lb_q == '0)) ? IW'(1) : la_w + lb_w - IW'(1);
              k_d     = '0;
              i_d     = ilo;
              start_k = 1'b1;
              state_d = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (last_issue) begin
          state_d = ST_DRAIN;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_fire) begin
          if (last_k) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_nxt;
            i_d     = ilo;
            start_k = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      la_q    <= '0;
      lb_q    <= '0;
      op_q    <= OP_ADD;
      zero_q  <= 1'b0;
      n_q     <= '0;
      k_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      la_q    <= la_d;
      lb_q    <= lb_d;
      op_q    <= op_d;
      zero_q  <= zero_d;
      n_q     <= n_d;
      k_q     <= k_d;
      i_q     <= i_d;
    end
  end

  // Power p of an operand sits at address len-1-p
  assign ia       = (op_q == OP_MUL) ? i_q : k_q;
  assign jb       = (op_q == OP_MUL) ? k_q - i_q : k_q;
  assign a_addr_w = la_w - IW'(1) - ia;
  assign b_addr_w = lb_w - IW'(1) - jb;

  assign issue.vld  = (state_q == ST_RUN);
  assign issue.a_ok = !zero_q && ((op_q == OP_MUL) || (k_q < la_w));
  assign issue.b_ok = !zero_q && ((op_q == OP_MUL) || (k_q < lb_w));

  pasm_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TERMS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (la_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (a_addr_w[AW-1:0]),
    .rdata_o (rd_a)
  );

  pasm_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TERMS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (lb_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (b_addr_w[AW-1:0]),
    .rdata_o (rd_b)
  );

  pasm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (start_k),
    .op_i    (op_q),
    .issue_i (issue),
    .rd_a_i  (rd_a),
    .rd_b_i  (rd_b),
    .acc_o   (acc),
    .busy_o  (mac_busy)
  );

  // Hold the finished coefficient on the output until taken
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {2'b00, POWER_W'(k_q), acc};
  assign m_axis_tlast  = last_k;

  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result word is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (la_q <= FULL) && (lb_q <= FULL))
    else $error("operand length beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && op_q == OP_MUL && !zero_q) |-> (i_q <= ihi) && (ilo <= la_w))
    else $error("multiply index outside the overlap range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after the final word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> !mac_busy)
    else $error("result shown while terms are still in flight");

endmodule : polynomial_add_sub_mul
`default_nettype wire

>>> rtl/core/pasm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pasm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pasm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : pasm_ram
`default_nettype wire

>>> rtl/core/pasm_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pasm_mac
// Three-stage datapath: mask the read coefficients, form the term
// (sum, difference or product), accumulate it into one result coefficient.
// ----------------------------------------------------------------------------
module pasm_mac (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              clr_i,
  input  wire pasm_pkg::op_e                     op_i,
  input  wire pasm_pkg::issue_t                  issue_i,
  input  wire logic [pasm_pkg::COEF_W-1:0]       rd_a_i,
  input  wire logic [pasm_pkg::COEF_W-1:0]       rd_b_i,
  output logic      [pasm_pkg::RESULT_W-1:0]     acc_o,
  output logic                                   busy_o
);
  import pasm_pkg::*;

  logic                       rdv_q;
  logic                       a_ok_q;
  logic                       b_ok_q;
  logic                       prv_q;
  logic signed [TERM_W-1:0]   term_q;
  logic signed [TERM_W-1:0]   term_d;
  logic signed [COEF_W-1:0]   a_s;
  logic signed [COEF_W-1:0]   b_s;
  logic        [RESULT_W-1:0] acc_q;
  logic        [RESULT_W-1:0] acc_d;

  // Track read data, which arrives in the cycle after the issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      prv_q <= 1'b0;
    end else begin
      rdv_q <= issue_i.vld;
      prv_q <= rdv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ok_q <= issue_i.a_ok;
    b_ok_q <= issue_i.b_ok;
  end

  // Drop coefficients that lie beyond an operand's length
  assign a_s = a_ok_q ? signed'(rd_a_i) : '0;
  assign b_s = b_ok_q ? signed'(rd_b_i) : '0;

  // Form the term
  always_comb begin
    case (op_i)
      OP_MUL:  term_d = a_s * b_s;
      OP_SUB:  term_d = {{COEF_W{a_s[COEF_W-1]}}, a_s} - {{COEF_W{b_s[COEF_W-1]}}, b_s};
      default: term_d = {{COEF_W{a_s[COEF_W-1]}}, a_s} + {{COEF_W{b_s[COEF_W-1]}}, b_s};
    endcase
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  // Accumulate the term, clear at the start of each coefficient
  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (prv_q) begin
      acc_d = acc_q + {{(RESULT_W-TERM_W){term_q[TERM_W-1]}}, term_q};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = rdv_q | prv_q;

  // Clearing only happens with an empty pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_i |-> !busy_o)
    else $error("accumulator cleared while terms are in flight");
  // A term stage is only loaded from a read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni) prv_q |-> $past(rdv_q))
    else $error("term stage valid without read data");
  // No issue on the cycle that clears
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_i |-> !issue_i.vld)
    else $error("issue coincides with accumulator clear");

endmodule : pasm_mac
`default_nettype wire
